FILE: design/run_slice_line_runs_fading_core_assert.svh
// Assertion macros shared by the checker of the run-slice line core.
// Needs a clock named clk and a reset named rst in the including scope.
`ifndef RUN_SLICE_LINE_RUNS_FADING_CORE_ASSERT_SVH
`define RUN_SLICE_LINE_RUNS_FADING_CORE_ASSERT_SVH
// Overlapping implication checked at every rising clock edge outside reset.
`define RSLF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rslf assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define RSLF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rslf assertion failed");
`endif

FILE: design/rslf_pkg.sv
// Package of the run-slice line core: field widths, constants, state and
// command types shared by the controller and the datapath. No dependencies.
package rslf_pkg;

  localparam int X_W = 9;
  localparam int Y_W = 8;
  localparam int COLOR_W = 8;
  localparam int LEN_W = 9;
  localparam int ADDR_W = 16;
  localparam int ERR_W = 12;
  localparam int MAX_RESULTS = 40;
  localparam int RCOUNT_W = 6;
  localparam int DIV_STEPS = X_W;
  localparam int DIV_CNT_W = 4;
  localparam logic [COLOR_W-1:0] FADE_FLOOR_RESET = 8'd216;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_PREP,
    S_FIRST,
    S_BODY,
    S_LAST,
    S_SIMPLE
  } state_t;

  typedef enum logic [1:0] {
    K_SIMPLE,
    K_FIRST,
    K_BODY,
    K_LAST
  } run_kind_t;

  typedef struct packed {
    logic      load;
    logic      div_step;
    logic      prep;
    logic      emit;
    logic      last_run;
    run_kind_t kind;
  } cmd_t;

  typedef struct packed {
    logic simple;
    logic div_done;
    logic cnt_zero;
    logic cnt_one;
    logic fade_stop;
    logic out_free;
  } stat_t;

endpackage

FILE: design/rslf_ctrl.sv
// Controller of the run-slice line core: sequences load, division, setup
// and run emission. Depends on rslf_pkg.
module rslf_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  rslf_pkg::stat_t stat,
  output rslf_pkg::cmd_t  cmd
);

  rslf_pkg::state_t state;
  rslf_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rslf_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    in_stall     = 1'b1;
    cmd.load     = 1'b0;
    cmd.div_step = 1'b0;
    cmd.prep     = 1'b0;
    cmd.emit     = 1'b0;
    cmd.last_run = 1'b0;
    cmd.kind     = rslf_pkg::K_SIMPLE;
    case (state)
      rslf_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = rslf_pkg::S_CHECK;
        end
      end
      rslf_pkg::S_CHECK: begin
        state_next = stat.simple ? rslf_pkg::S_SIMPLE : rslf_pkg::S_DIV;
      end
      rslf_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) begin
          state_next = rslf_pkg::S_PREP;
        end
      end
      rslf_pkg::S_PREP: begin
        cmd.prep   = 1'b1;
        state_next = rslf_pkg::S_FIRST;
      end
      rslf_pkg::S_FIRST: begin
        cmd.kind     = rslf_pkg::K_FIRST;
        cmd.last_run = stat.fade_stop;
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.fade_stop) begin
            state_next = rslf_pkg::S_IDLE;
          end else if (stat.cnt_zero) begin
            state_next = rslf_pkg::S_LAST;
          end else begin
            state_next = rslf_pkg::S_BODY;
          end
        end
      end
      rslf_pkg::S_BODY: begin
        cmd.kind     = rslf_pkg::K_BODY;
        cmd.last_run = stat.fade_stop;
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.fade_stop) begin
            state_next = rslf_pkg::S_IDLE;
          end else if (stat.cnt_one) begin
            state_next = rslf_pkg::S_LAST;
          end
        end
      end
      rslf_pkg::S_LAST: begin
        cmd.kind     = rslf_pkg::K_LAST;
        cmd.last_run = 1'b1;
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = rslf_pkg::S_IDLE;
        end
      end
      rslf_pkg::S_SIMPLE: begin
        cmd.kind     = rslf_pkg::K_SIMPLE;
        cmd.last_run = stat.fade_stop || stat.cnt_zero;
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (cmd.last_run) begin
            state_next = rslf_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_next = rslf_pkg::S_IDLE;
      end
    endcase
  end

endmodule

FILE: design/rslf_datapath.sv
// Datapath of the run-slice line core: endpoint setup, restoring divider,
// slice error term, position tracking and the result register.
// Depends on rslf_pkg.
module rslf_datapath #(
  parameter int SCREEN_WIDTH = 320
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [rslf_pkg::COLOR_W-1:0]  cfg_data,
  input  logic [rslf_pkg::X_W-1:0]      x_start,
  input  logic [rslf_pkg::Y_W-1:0]      y_start,
  input  logic [rslf_pkg::X_W-1:0]      x_end,
  input  logic [rslf_pkg::Y_W-1:0]      y_end,
  input  logic [rslf_pkg::COLOR_W-1:0]  start_color,
  input  rslf_pkg::cmd_t                cmd,
  output rslf_pkg::stat_t               stat,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rslf_pkg::ADDR_W-1:0]   run_address,
  output logic [rslf_pkg::LEN_W-1:0]    run_length,
  output logic                          run_vertical,
  output logic                          step_left,
  output logic [rslf_pkg::COLOR_W-1:0]  run_color,
  output logic                          last_run
);

  localparam int MULT_W = rslf_pkg::Y_W + $clog2(SCREEN_WIDTH + 1) + 1;

  logic [rslf_pkg::COLOR_W-1:0]  fade_floor;
  logic [rslf_pkg::X_W-1:0]      x;
  logic [rslf_pkg::Y_W-1:0]      y;
  logic                          left;
  logic                          vert;
  logic                          ystep;
  logic                          simple;
  logic [rslf_pkg::COLOR_W-1:0]  color;
  logic [rslf_pkg::RCOUNT_W-1:0] rcount;
  logic [rslf_pkg::X_W-1:0]      cnt;
  logic [rslf_pkg::X_W-1:0]      dq;
  logic [rslf_pkg::X_W-1:0]      dr;
  logic [rslf_pkg::X_W-1:0]      dd;
  logic [rslf_pkg::DIV_CNT_W-1:0] dcnt;
  logic [rslf_pkg::X_W-1:0]      whole;
  logic [rslf_pkg::X_W:0]        adj_up;
  logic [rslf_pkg::X_W:0]        adj_down;
  logic signed [rslf_pkg::ERR_W-1:0] err;
  logic [rslf_pkg::LEN_W-1:0]    first_len;
  logic [rslf_pkg::LEN_W-1:0]    last_len;

  logic                          swap;
  logic [rslf_pkg::X_W-1:0]      xa;
  logic [rslf_pkg::X_W-1:0]      xb;
  logic [rslf_pkg::Y_W-1:0]      ya;
  logic [rslf_pkg::Y_W-1:0]      yb;
  logic [rslf_pkg::X_W:0]        dxs;
  logic [rslf_pkg::X_W-1:0]      dx;
  logic [rslf_pkg::X_W-1:0]      dy;
  logic                          xmajor;
  logic [rslf_pkg::X_W:0]        dtrial;
  logic                          dge;
  logic [rslf_pkg::X_W-1:0]      half;
  logic signed [rslf_pkg::ERR_W-1:0] err_init;
  logic signed [rslf_pkg::ERR_W-1:0] err_up;
  logic                          body_long;
  logic [rslf_pkg::LEN_W-1:0]    len_sel;
  logic [MULT_W-1:0]             addr_full;

  always_comb begin
    swap   = y_start > y_end;
    xa     = swap ? x_end : x_start;
    xb     = swap ? x_start : x_end;
    ya     = swap ? y_end : y_start;
    yb     = swap ? y_start : y_end;
    dxs    = {1'b0, xb} - {1'b0, xa};
    dx     = dxs[rslf_pkg::X_W] ? rslf_pkg::X_W'(-dxs) : dxs[rslf_pkg::X_W-1:0];
    dy     = rslf_pkg::X_W'(yb - ya);
    xmajor = dx > dy;

    dtrial = {dr, dq[rslf_pkg::X_W-1]};
    dge    = dtrial >= {1'b0, dd};

    half     = (dq >> 1) + rslf_pkg::X_W'(1);
    err_init = rslf_pkg::ERR_W'(dr) - rslf_pkg::ERR_W'({dd, 1'b0})
             + (dq[0] ? rslf_pkg::ERR_W'(dd) : rslf_pkg::ERR_W'(0));

    err_up    = err + rslf_pkg::ERR_W'(adj_up);
    body_long = err_up > 0;

    case (cmd.kind)
      rslf_pkg::K_SIMPLE: len_sel = rslf_pkg::LEN_W'(1);
      rslf_pkg::K_FIRST:  len_sel = first_len;
      rslf_pkg::K_BODY:   len_sel = body_long ? whole + rslf_pkg::LEN_W'(1) : whole;
      rslf_pkg::K_LAST:   len_sel = last_len;
      default:            len_sel = rslf_pkg::LEN_W'(1);
    endcase

    addr_full = MULT_W'(y) * MULT_W'(SCREEN_WIDTH) + MULT_W'(x);

    stat.simple    = simple;
    stat.div_done  = dcnt == rslf_pkg::DIV_CNT_W'(rslf_pkg::DIV_STEPS - 1);
    stat.cnt_zero  = cnt == '0;
    stat.cnt_one   = cnt == rslf_pkg::X_W'(1);
    stat.fade_stop = (color <= fade_floor) ||
                     (rcount == rslf_pkg::RCOUNT_W'(rslf_pkg::MAX_RESULTS - 1));
    stat.out_free  = !out_valid || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fade_floor <= rslf_pkg::FADE_FLOOR_RESET;
    end else if (cfg_we) begin
      fade_floor <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x      <= xa;
      y      <= ya;
      left   <= dxs[rslf_pkg::X_W];
      color  <= start_color;
      rcount <= '0;
      ystep  <= dy != '0;
      simple <= (dx == '0) || (dy == '0) || (dx == dy);
      vert   <= ((dx == '0) || (dy == '0) || (dx == dy)) ? (dx == '0) : !xmajor;
      cnt    <= (dx == '0) ? dy : dx;
      dq     <= xmajor ? dx : dy;
      dd     <= xmajor ? dy : dx;
      dr     <= '0;
      dcnt   <= '0;
    end
    if (cmd.div_step) begin
      dr   <= dge ? rslf_pkg::X_W'(dtrial - {1'b0, dd}) : dtrial[rslf_pkg::X_W-1:0];
      dq   <= {dq[rslf_pkg::X_W-2:0], dge};
      dcnt <= dcnt + rslf_pkg::DIV_CNT_W'(1);
    end
    if (cmd.prep) begin
      whole     <= dq;
      adj_up    <= {dr, 1'b0};
      adj_down  <= {dd, 1'b0};
      err       <= err_init;
      last_len  <= half;
      first_len <= ((dr == '0) && !dq[0]) ? half - rslf_pkg::X_W'(1) : half;
      cnt       <= dd - rslf_pkg::X_W'(1);
    end
    if (cmd.emit) begin
      run_address  <= rslf_pkg::ADDR_W'(addr_full);
      run_length   <= len_sel;
      run_vertical <= vert;
      step_left    <= left;
      run_color    <= color;
      last_run     <= cmd.last_run;
      color        <= color - rslf_pkg::COLOR_W'(1);
      rcount       <= rcount + rslf_pkg::RCOUNT_W'(1);
      if (cmd.kind == rslf_pkg::K_SIMPLE) begin
        cnt <= cnt - rslf_pkg::X_W'(1);
        if (vert) begin
          y <= y + rslf_pkg::Y_W'(1);
        end else begin
          x <= left ? x - rslf_pkg::X_W'(1) : x + rslf_pkg::X_W'(1);
          y <= y + rslf_pkg::Y_W'(ystep);
        end
      end else begin
        if (cmd.kind == rslf_pkg::K_BODY) begin
          cnt <= cnt - rslf_pkg::X_W'(1);
          err <= body_long ? err_up - rslf_pkg::ERR_W'(adj_down) : err_up;
        end
        if (vert) begin
          y <= y + rslf_pkg::Y_W'(len_sel);
          x <= left ? x - rslf_pkg::X_W'(1) : x + rslf_pkg::X_W'(1);
        end else begin
          x <= left ? x - len_sel : x + len_sel;
          y <= y + rslf_pkg::Y_W'(1);
        end
      end
    end
  end

endmodule

FILE: design/run_slice_line_runs_fading_core.sv
// Run-slice line core. One line command is taken only while the core is idle.
// Slanted lines run setup (load, check, nine divider steps, error setup),
// then give one run per cycle while the output is not stalled; lines that
// are purely horizontal, vertical or diagonal need only load and check.
// The divider loop sets the setup time, the output register the run rate.
// Reset is synchronous and active high; it sets fade_floor to 216 and idles.
module run_slice_line_runs_fading_core #(
  parameter int SCREEN_WIDTH = 320
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [rslf_pkg::COLOR_W-1:0] cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [rslf_pkg::X_W-1:0]     x_start,
  input  logic [rslf_pkg::Y_W-1:0]     y_start,
  input  logic [rslf_pkg::X_W-1:0]     x_end,
  input  logic [rslf_pkg::Y_W-1:0]     y_end,
  input  logic [rslf_pkg::COLOR_W-1:0] start_color,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [rslf_pkg::ADDR_W-1:0]  run_address,
  output logic [rslf_pkg::LEN_W-1:0]   run_length,
  output logic                         run_vertical,
  output logic                         step_left,
  output logic [rslf_pkg::COLOR_W-1:0] run_color,
  output logic                         last_run
);

  rslf_pkg::cmd_t  cmd;
  rslf_pkg::stat_t stat;

  rslf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  rslf_datapath #(
    .SCREEN_WIDTH (SCREEN_WIDTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .x_start      (x_start),
    .y_start      (y_start),
    .x_end        (x_end),
    .y_end        (y_end),
    .start_color  (start_color),
    .cmd          (cmd),
    .stat         (stat),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .run_address  (run_address),
    .run_length   (run_length),
    .run_vertical (run_vertical),
    .step_left    (step_left),
    .run_color    (run_color),
    .last_run     (last_run)
  );

endmodule

FILE: design/rslf_checker.sv
// Port-level checker of the run-slice line core, bound to the top level.
// Depends on run_slice_line_runs_fading_core_assert.svh and rslf_pkg.
`include "run_slice_line_runs_fading_core_assert.svh"
module rslf_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [rslf_pkg::ADDR_W-1:0]  run_address,
  input logic [rslf_pkg::LEN_W-1:0]   run_length
);

  `RSLF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  `RSLF_ASSERT_NEXT(a_addr_hold, out_valid && out_stall, $stable(run_address))
  `RSLF_ASSERT_NOW(a_len_nonzero, out_valid, run_length != '0)
  `RSLF_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

endmodule

bind run_slice_line_runs_fading_core rslf_checker u_rslf_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .run_address (run_address),
  .run_length  (run_length)
);

FILE: test/run_slice_line_runs_fading_core_test.sv
// Testbench of the run-slice line core: directed table, then random line commands,
// every run checked against a behavioral run generator. Needs rslf_pkg and the core.
`timescale 1ns / 1ps

module run_slice_line_runs_fading_core_test;

  typedef struct packed {
    logic [rslf_pkg::ADDR_W-1:0]  addr;
    logic [rslf_pkg::LEN_W-1:0]   len;
    logic                         vert;
    logic                         left;
    logic [rslf_pkg::COLOR_W-1:0] color;
    logic                         last;
  } run_t;

  typedef struct {
    logic [rslf_pkg::X_W-1:0]     x0;
    logic [rslf_pkg::Y_W-1:0]     y0;
    logic [rslf_pkg::X_W-1:0]     x1;
    logic [rslf_pkg::Y_W-1:0]     y1;
    logic [rslf_pkg::COLOR_W-1:0] color;
    bit                           typed;
    run_t                         first_run;
  } line_row_t;

  localparam int WIDTH = 320;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [rslf_pkg::COLOR_W-1:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_stall;
  logic [rslf_pkg::X_W-1:0] x_start = '0;
  logic [rslf_pkg::Y_W-1:0] y_start = '0;
  logic [rslf_pkg::X_W-1:0] x_end = '0;
  logic [rslf_pkg::Y_W-1:0] y_end = '0;
  logic [rslf_pkg::COLOR_W-1:0] start_color = '0;
  logic out_valid;
  logic out_stall = 0;
  logic [rslf_pkg::ADDR_W-1:0] run_address;
  logic [rslf_pkg::LEN_W-1:0] run_length;
  logic run_vertical, step_left, last_run;
  logic [rslf_pkg::COLOR_W-1:0] run_color;

  run_t expected_runs[$];
  line_row_t line_table[$];
  logic [rslf_pkg::COLOR_W-1:0] floor_value = rslf_pkg::FADE_FLOOR_RESET;
  int failures = 0;
  int runs_seen = 0;
  int lines_sent = 0;
  bit stimulus_done = 0;
  bit check_first = 0;
  run_t first_expect;

  always #2 clk = ~clk;

  run_slice_line_runs_fading_core #(.SCREEN_WIDTH(WIDTH)) u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .x_start(x_start), .y_start(y_start), .x_end(x_end), .y_end(y_end),
    .start_color(start_color),
    .out_valid(out_valid), .out_stall(out_stall),
    .run_address(run_address), .run_length(run_length), .run_vertical(run_vertical),
    .step_left(step_left), .run_color(run_color), .last_run(last_run)
  );

  int run_count;
  longint run_shade;

  function automatic bit push_run(longint x, longint y, longint len, bit vert, bit left,
                                  bit final_run);
    run_t r;
    bit stop;
    stop = final_run || (run_shade - 1 < longint'(floor_value)) || (run_count + 1 >= 40);
    r.addr = rslf_pkg::ADDR_W'(y * WIDTH + x);
    r.len = rslf_pkg::LEN_W'(len);
    r.vert = vert;
    r.left = left;
    r.color = rslf_pkg::COLOR_W'(run_shade);
    r.last = stop;
    expected_runs.push_back(r);
    run_count++;
    run_shade--;
    return !stop;
  endfunction

  task automatic predict_line_runs(longint xa, longint ya, longint xb, longint yb,
                                   longint shade);
    longint t, dx, dy, adv, x, y, major, minor, whole, rem, up, down, err, first, len;
    bit left, xmajor, vert;
    run_count = 0;
    run_shade = shade;
    if (ya > yb) begin
      t = ya; ya = yb; yb = t;
      t = xa; xa = xb; xb = t;
    end
    dx = xb - xa;
    adv = 1;
    if (dx < 0) begin
      adv = -1;
      dx = -dx;
    end
    left = adv < 0;
    dy = yb - ya;
    x = xa;
    y = ya;
    if (dx == 0) begin
      for (longint i = 0; i <= dy; i++)
        if (!push_run(x, y + i, 1, 1'b1, left, i == dy)) return;
      return;
    end
    if (dy == 0 || dx == dy) begin
      for (longint i = 0; i <= dx; i++)
        if (!push_run(x + i * adv, y + i * (dy == 0 ? 0 : 1), 1, 1'b0, left, i == dx))
          return;
      return;
    end
    xmajor = dx > dy;
    major = xmajor ? dx : dy;
    minor = xmajor ? dy : dx;
    vert = !xmajor;
    whole = major / minor;
    rem = major % minor;
    up = rem * 2;
    down = minor * 2;
    err = rem - minor * 2;
    first = whole / 2 + 1;
    len = first;
    if (up == 0 && whole[0] == 0) first--;
    if (whole[0]) err += minor;
    if (!push_run(x, y, first, vert, left, 1'b0)) return;
    if (xmajor) begin
      x += first * adv;
      y += 1;
    end else begin
      y += first;
      x += adv;
    end
    for (longint i = 0; i < minor - 1; i++) begin
      first = whole;
      err += up;
      if (err > 0) begin
        first++;
        err -= down;
      end
      if (!push_run(x, y, first, vert, left, 1'b0)) return;
      if (xmajor) begin
        x += first * adv;
        y += 1;
      end else begin
        y += first;
        x += adv;
      end
    end
    void'(push_run(x, y, len, vert, left, 1'b1));
  endtask

  always @(posedge clk) begin
    run_t got, exp;
    if (!rst && out_valid && !out_stall) begin
      got = '{run_address, run_length, run_vertical, step_left, run_color, last_run};
      runs_seen++;
      if (expected_runs.size() == 0) begin
        failures++;
        $display("%0t: unexpected run %p", $time, got);
      end else begin
        exp = expected_runs.pop_front();
        if (check_first) begin
          check_first <= 0;
          if (got != first_expect) begin
            failures++;
            $display("%0t: table run expected %p actual %p", $time, first_expect, got);
          end
        end
        if (got.addr != exp.addr) begin
          failures++;
          $display("%0t: run_address expected %0d actual %0d", $time, exp.addr, got.addr);
        end
        if (got.len != exp.len) begin
          failures++;
          $display("%0t: run_length expected %0d actual %0d", $time, exp.len, got.len);
        end
        if (got.vert != exp.vert) begin
          failures++;
          $display("%0t: run_vertical expected %0b actual %0b", $time, exp.vert, got.vert);
        end
        if (got.left != exp.left) begin
          failures++;
          $display("%0t: step_left expected %0b actual %0b", $time, exp.left, got.left);
        end
        if (got.color != exp.color) begin
          failures++;
          $display("%0t: run_color expected %0d actual %0d", $time, exp.color, got.color);
        end
        if (got.last != exp.last) begin
          failures++;
          $display("%0t: last_run expected %0b actual %0b", $time, exp.last, got.last);
        end
      end
    end
  end

  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  initial begin
    bit stall_free;
    int n;
    stall_free = 0;
    forever begin
      @(negedge clk);
      if (!stimulus_done && $urandom_range(0, 199) == 0) stall_free = !stall_free;
      n = stall_free ? 0 : gap_length();
      if (n != 0) begin
        out_stall <= 1;
        repeat (n) @(negedge clk);
        out_stall <= 0;
      end
    end
  end

  task automatic send_line(line_row_t row);
    int n;
    n = gap_length();
    @(negedge clk);
    if (row.typed || n != 0) begin
      in_valid <= 0;
      while (row.typed && expected_runs.size() != 0) @(negedge clk);
      repeat (n + 1) @(negedge clk);
    end
    x_start <= row.x0;
    y_start <= row.y0;
    x_end <= row.x1;
    y_end <= row.y1;
    start_color <= row.color;
    in_valid <= 1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (row.typed) begin
      first_expect = row.first_run;
      check_first = expected_runs.size() == 0;
    end
    predict_line_runs(longint'(row.x0), longint'(row.y0), longint'(row.x1),
                      longint'(row.y1), longint'(row.color));
    lines_sent++;
  endtask

  task automatic write_floor(logic [rslf_pkg::COLOR_W-1:0] value);
    @(negedge clk);
    in_valid <= 0;
    while (expected_runs.size() != 0) @(negedge clk);
    repeat (16) @(negedge clk);
    cfg_data <= value;
    cfg_we <= 1;
    @(negedge clk);
    cfg_we <= 0;
    floor_value = value;
  endtask

  function automatic line_row_t random_line();
    line_row_t r;
    int kind;
    r.typed = 1'b0;
    r.x0 = rslf_pkg::X_W'($urandom_range(0, 319));
    r.y0 = rslf_pkg::Y_W'($urandom_range(0, 199));
    kind = $urandom_range(0, 9);
    case (kind)
      0: begin
        r.x1 = r.x0;
        r.y1 = rslf_pkg::Y_W'($urandom_range(0, 199));
      end
      1: begin
        r.x1 = rslf_pkg::X_W'($urandom_range(0, 319));
        r.y1 = r.y0;
      end
      2: begin
        r.x1 = $urandom_range(0, 1) ? r.x0 + 9'd5 : r.x0 - 9'd5;
        r.y1 = r.y0 + 8'd5;
        if (r.x1 > 319 || r.y1 > 199) r.x1 = r.x0;
      end
      3: begin
        r.x1 = rslf_pkg::X_W'($urandom_range(0, 511));
        r.y1 = rslf_pkg::Y_W'($urandom_range(0, 255));
        r.x0 = rslf_pkg::X_W'($urandom_range(0, 511));
        r.y0 = rslf_pkg::Y_W'($urandom_range(0, 255));
      end
      default: begin
        r.x1 = rslf_pkg::X_W'($urandom_range(0, 319));
        r.y1 = rslf_pkg::Y_W'($urandom_range(0, 199));
      end
    endcase
    r.color = rslf_pkg::COLOR_W'($urandom_range(0, 2) == 0 ? $urandom_range(0, 255)
                                                           : $urandom_range(200, 255));
    return r;
  endfunction

  initial begin
    line_row_t row;
    line_table = '{
      '{9'd0, 8'd0, 9'd0, 8'd0, 8'd255, 1'b1, '{16'd0, 9'd1, 1'b1, 1'b0, 8'd255, 1'b1}},
      '{9'd319, 8'd199, 9'd319, 8'd199, 8'd0, 1'b1,
        '{16'd63999, 9'd1, 1'b1, 1'b0, 8'd0, 1'b1}},
      '{9'd0, 8'd0, 9'd319, 8'd0, 8'd255, 1'b1, '{16'd0, 9'd1, 1'b0, 1'b0, 8'd255, 1'b0}},
      '{9'd10, 8'd0, 9'd0, 8'd10, 8'd250, 1'b1, '{16'd10, 9'd1, 1'b0, 1'b1, 8'd250, 1'b0}},
      '{9'd5, 8'd0, 9'd5, 8'd199, 8'd230, 1'b1, '{16'd5, 9'd1, 1'b1, 1'b0, 8'd230, 1'b0}},
      '{9'd0, 8'd0, 9'd319, 8'd199, 8'd255, 1'b0, '0},
      '{9'd319, 8'd0, 9'd0, 8'd199, 8'd255, 1'b0, '0},
      '{9'd0, 8'd199, 9'd319, 8'd0, 8'd255, 1'b0, '0},
      '{9'd0, 8'd0, 9'd3, 8'd1, 8'd255, 1'b0, '0},
      '{9'd0, 8'd0, 9'd4, 8'd1, 8'd255, 1'b0, '0},
      '{9'd0, 8'd0, 9'd1, 8'd3, 8'd255, 1'b0, '0},
      '{9'd100, 8'd0, 9'd0, 8'd199, 8'd255, 1'b0, '0},
      '{9'd511, 8'd255, 9'd0, 8'd0, 8'd255, 1'b0, '0},
      '{9'd0, 8'd0, 9'd300, 8'd7, 8'd100, 1'b0, '0},
      '{9'd170, 8'd85, 9'd85, 8'd170, 8'd217, 1'b0, '0}
    };
    rst = 1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 0;
    foreach (line_table[i]) send_line(line_table[i]);
    write_floor(8'd0);
    for (int i = 0; i < 40; i++) send_line(random_line());
    write_floor(8'd255);
    for (int i = 0; i < 30; i++) send_line(random_line());
    write_floor(rslf_pkg::COLOR_W'($urandom_range(150, 240)));
    for (int i = 0; i < 80; i++) send_line(random_line());
    @(negedge clk);
    in_valid <= 0;
    while (expected_runs.size() != 0) @(negedge clk);
    stimulus_done = 1;
    repeat (60) @(negedge clk);
    $display("Sent %0d line commands over four fade floors; checked %0d runs.",
             lines_sent, runs_seen);
    if (failures == 0) $display("run_slice_line_runs_fading_core regression: pass");
    else $display("run_slice_line_runs_fading_core regression: fail");
    $finish;
  end

  initial begin
    #20ms;
    $display("run_slice_line_runs_fading_core regression: fail");
    $finish;
  end

endmodule
